FILE: rtl/esp_pkg.sv
// Shared types, constants and register indexes for the ESP encapsulation framer.
package esp_pkg;

  localparam int MAX_IV_BYTES   = 16;
  localparam int MAX_ICV_BYTES  = 16;
  localparam int MAX_BLK_LOG2   = 4;
  localparam int MIN_ALIGN_LOG2 = 2;
  localparam int HDR_BYTES      = 8;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;
  localparam int Q_DEPTH        = 4;
  localparam int Q_AW           = $clog2(Q_DEPTH);

  typedef enum logic [CFG_AW-1:0] {
    REG_SPI        = 3'd0,
    REG_USER_HDR   = 3'd1,
    REG_BLK_LOG2   = 3'd2,
    REG_IV_LEN     = 3'd3,
    REG_AUTH_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic        hdr;
    logic        pay;
    logic        tail;
    logic [7:0]  data;
    logic [31:0] spi;
    logic [31:0] seq;
    logic [4:0]  iv;
    logic [3:0]  pad;
    logic [7:0]  nh;
    logic [4:0]  icv;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR  = 4'd1,
    PH_IV   = 4'd2,
    PH_PAY  = 4'd3,
    PH_PAD  = 4'd4,
    PH_PLEN = 4'd5,
    PH_NH   = 4'd6,
    PH_ICV  = 4'd7,
    PH_DONE = 4'd8
  } phase_t;

endpackage

FILE: rtl/esp_front.sv
// Input classifier: config registers, per-packet state and command generation.
module esp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [esp_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [esp_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_push,
  input  esp_pkg::in_item_t           in_data,
  output logic                        in_full,
  output esp_pkg::q_wr_t              q_wr,
  input  logic                        q_full,
  output esp_pkg::cmd_t               q_cmd
);

  logic [31:0] spi_r;
  logic        uhm_r;
  logic [2:0]  blk_r;
  logic [4:0]  iv_len_r;
  logic [4:0]  auth_len_r;

  logic [31:0] seq_r, seq_nxt;
  logic [3:0]  lm_r, lm_nxt;
  logic [1:0]  ub_r, ub_nxt;
  logic [7:0]  nh_r, nh_nxt;
  logic        hs_r, hs_nxt;

  logic        accept;
  logic        do_push;
  logic        do_hdr, do_pay, do_tail;
  logic [4:0]  iv_sat, icv_sat;
  logic [2:0]  lg_sat, lg_eff;
  logic [3:0]  align_mask;
  logic [3:0]  pad;
  logic [7:0]  nh_cmd;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spi_r      <= '0;
      uhm_r      <= 1'b0;
      blk_r      <= '0;
      iv_len_r   <= '0;
      auth_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        esp_pkg::REG_SPI:      spi_r      <= cfg_data;
        esp_pkg::REG_USER_HDR: uhm_r      <= cfg_data[0];
        esp_pkg::REG_BLK_LOG2: blk_r      <= cfg_data[2:0];
        esp_pkg::REG_IV_LEN:   iv_len_r   <= cfg_data[4:0];
        esp_pkg::REG_AUTH_LEN: auth_len_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    iv_sat  = (iv_len_r > 5'(esp_pkg::MAX_IV_BYTES)) ? 5'(esp_pkg::MAX_IV_BYTES) : iv_len_r;
    icv_sat = (auth_len_r > 5'(esp_pkg::MAX_ICV_BYTES)) ?
              5'(esp_pkg::MAX_ICV_BYTES) : auth_len_r;
    lg_sat  = (blk_r > 3'(esp_pkg::MAX_BLK_LOG2)) ? 3'(esp_pkg::MAX_BLK_LOG2) : blk_r;
    lg_eff  = (lg_sat < 3'(esp_pkg::MIN_ALIGN_LOG2)) ? 3'(esp_pkg::MIN_ALIGN_LOG2) : lg_sat;
    align_mask = 4'((5'd1 << lg_eff) - 5'd1);
  end

  always_comb begin
    seq_nxt = seq_r;
    lm_nxt  = lm_r;
    ub_nxt  = ub_r;
    nh_nxt  = nh_r;
    hs_nxt  = hs_r;
    do_hdr  = 1'b0;
    do_pay  = 1'b0;
    do_tail = 1'b0;
    do_push = 1'b0;
    pad     = '0;
    nh_cmd  = nh_r;
    if (accept) begin
      if (!hs_r) begin
        if (uhm_r) begin
          if (ub_r == 2'd0) begin
            nh_nxt = in_data.data_byte;
          end
          if (ub_r != 2'd3) begin
            ub_nxt = ub_r + 2'd1;
          end else begin
            ub_nxt  = '0;
            do_hdr  = 1'b1;
            do_push = 1'b1;
          end
        end else begin
          nh_nxt  = '0;
          ub_nxt  = '0;
          do_hdr  = 1'b1;
          do_pay  = 1'b1;
          do_push = 1'b1;
        end
      end else begin
        do_pay  = 1'b1;
        do_push = 1'b1;
      end
      if (do_hdr) begin
        seq_nxt = seq_r + 32'd1;
        lm_nxt  = iv_sat[3:0];
        hs_nxt  = 1'b1;
      end
      if (do_pay) begin
        lm_nxt = lm_nxt + 4'd1;
      end
      do_tail = do_push && in_data.last_byte;
      pad     = align_mask - ((lm_nxt + 4'd1) & align_mask);
      nh_cmd  = nh_nxt;
      if (in_data.last_byte) begin
        lm_nxt = '0;
        ub_nxt = '0;
        nh_nxt = '0;
        hs_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      lm_r  <= '0;
      ub_r  <= '0;
      nh_r  <= '0;
      hs_r  <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      lm_r  <= lm_nxt;
      ub_r  <= ub_nxt;
      nh_r  <= nh_nxt;
      hs_r  <= hs_nxt;
    end
  end

  assign q_wr.push = do_push;
  assign q_wr.full = q_full;

  always_comb begin
    q_cmd.hdr  = do_hdr;
    q_cmd.pay  = do_pay;
    q_cmd.tail = do_tail;
    q_cmd.data = in_data.data_byte;
    q_cmd.spi  = spi_r;
    q_cmd.seq  = seq_nxt;
    q_cmd.iv   = iv_sat;
    q_cmd.pad  = pad;
    q_cmd.nh   = nh_cmd;
    q_cmd.icv  = icv_sat;
  end

endmodule

FILE: rtl/esp_cmdq.sv
// Short command queue between the classifier and the output sequencer.
module esp_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  esp_pkg::cmd_t  wr_cmd,
  input  logic           pop,
  output esp_pkg::cmd_t  rd_cmd,
  output logic           full,
  output logic           empty
);

  esp_pkg::cmd_t             mem_r [esp_pkg::Q_DEPTH];
  logic [esp_pkg::Q_AW-1:0]  wp_r, wp_nxt;
  logic [esp_pkg::Q_AW-1:0]  rp_r, rp_nxt;
  logic [esp_pkg::Q_AW:0]    cnt_r, cnt_nxt;

  assign full   = (cnt_r == (esp_pkg::Q_AW+1)'(esp_pkg::Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (esp_pkg::Q_AW+1)'(push) - (esp_pkg::Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("command queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (esp_pkg::Q_AW+1)'(esp_pkg::Q_DEPTH))
    else $error("command queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue count lost a push");
`endif

endmodule

FILE: rtl/esp_back.sv
// Output sequencer: expands commands into frame bytes behind an output register.
module esp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  esp_pkg::cmd_t      cmd,
  input  esp_pkg::q_rd_t     q_in,
  output logic               q_pop,
  output logic               out_valid,
  output esp_pkg::out_item_t out_item,
  input  logic               out_pop
);

  esp_pkg::phase_t    st_r, st_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  esp_pkg::phase_t    cur_ph, nxt_ph;
  logic [4:0]         cur_cnt;
  logic [4:0]         ph_len;
  logic               step_done;
  logic               emit;
  logic               out_valid_r, out_valid_nxt;
  esp_pkg::out_item_t out_r, out_nxt;
  esp_pkg::out_item_t byte_now;

  function automatic esp_pkg::phase_t phase_from(input esp_pkg::cmd_t c,
                                                 input esp_pkg::phase_t p);
    esp_pkg::phase_t r;
    if (p <= esp_pkg::PH_HDR && c.hdr) r = esp_pkg::PH_HDR;
    else if (p <= esp_pkg::PH_IV && c.hdr && c.iv != '0) r = esp_pkg::PH_IV;
    else if (p <= esp_pkg::PH_PAY && c.pay) r = esp_pkg::PH_PAY;
    else if (p <= esp_pkg::PH_PAD && c.tail && c.pad != '0) r = esp_pkg::PH_PAD;
    else if (p <= esp_pkg::PH_PLEN && c.tail) r = esp_pkg::PH_PLEN;
    else if (p <= esp_pkg::PH_NH && c.tail) r = esp_pkg::PH_NH;
    else if (p <= esp_pkg::PH_ICV && c.tail && c.icv != '0) r = esp_pkg::PH_ICV;
    else r = esp_pkg::PH_DONE;
    return r;
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  assign emit = !q_in.empty && (!out_valid_r || out_pop);

  always_comb begin
    cur_ph  = (st_r == esp_pkg::PH_IDLE) ? phase_from(cmd, esp_pkg::PH_HDR) : st_r;
    cur_cnt = (st_r == esp_pkg::PH_IDLE) ? 5'd0 : cnt_r;
    byte_now.frame_byte = 8'd0;
    byte_now.frame_last = 1'b0;
    case (cur_ph)
      esp_pkg::PH_HDR: begin
        ph_len = 5'(esp_pkg::HDR_BYTES);
        byte_now.frame_byte = cur_cnt[2] ? word_byte(cmd.seq, cur_cnt[1:0])
                                         : word_byte(cmd.spi, cur_cnt[1:0]);
      end
      esp_pkg::PH_IV:  ph_len = cmd.iv;
      esp_pkg::PH_PAY: begin
        ph_len = 5'd1;
        byte_now.frame_byte = cmd.data;
      end
      esp_pkg::PH_PAD: ph_len = {1'b0, cmd.pad};
      esp_pkg::PH_PLEN: begin
        ph_len = 5'd1;
        byte_now.frame_byte = {4'd0, cmd.pad};
      end
      esp_pkg::PH_NH: begin
        ph_len = 5'd1;
        byte_now.frame_byte = cmd.nh;
        byte_now.frame_last = (cmd.icv == '0);
      end
      esp_pkg::PH_ICV: begin
        ph_len = cmd.icv;
        byte_now.frame_last = (cur_cnt + 5'd1 == cmd.icv);
      end
      default: ph_len = 5'd1;
    endcase
    step_done = (cur_cnt + 5'd1 == ph_len);
    nxt_ph    = step_done ? phase_from(cmd, esp_pkg::phase_t'(4'(cur_ph) + 4'd1)) : cur_ph;

    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (emit) begin
      out_nxt       = byte_now;
      out_valid_nxt = 1'b1;
      if (nxt_ph == esp_pkg::PH_DONE) begin
        q_pop   = 1'b1;
        st_nxt  = esp_pkg::PH_IDLE;
        cnt_nxt = '0;
      end else begin
        st_nxt  = nxt_ph;
        cnt_nxt = step_done ? 5'd0 : cur_cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= esp_pkg::PH_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: rtl/esp_encapsulation_framer.sv
// Top level of the ESP encapsulation framer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | in        | in_push / in_full  | in_data: data_byte, last_byte
//  out_    | out       | out_pop / out_empty| out_data: frame_byte, frame_last
//  cfg_    | in        | cfg_we             | cfg_addr, cfg_data (no read-back)
//
// One input byte is taken per cycle while the command queue has room; the output
// sequencer sends one frame byte per cycle while a command is queued and the output
// register is free or popped, so header and tail bursts (8 + IV and pad + 2 + ICV
// bytes) are set by that single output port and absorbed by the queue. Reset is
// synchronous, active low. in_full follows the command queue; out_empty follows the output register.
module esp_encapsulation_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [esp_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [esp_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_push,
  input  esp_pkg::in_item_t           in_data,
  output logic                        in_full,
  output logic                        out_empty,
  input  logic                        out_pop,
  output esp_pkg::out_item_t          out_data
);

  esp_pkg::q_wr_t q_wr;
  esp_pkg::q_rd_t q_rd;
  esp_pkg::cmd_t  wr_cmd;
  esp_pkg::cmd_t  rd_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           out_valid;

  esp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_cmd    (wr_cmd)
  );

  esp_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_wr.push),
    .wr_cmd (wr_cmd),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  assign q_rd.pop   = q_pop;
  assign q_rd.empty = q_empty;

  esp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .q_in      (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_pop   (out_pop)
  );

  assign out_empty = !out_valid;

endmodule
